### rtl/core/assert_macros.svh
// Assertion macros used by the core back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define SME_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next edge
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sme_pkg.sv
// Types and constants shared by the stack machine executor
`timescale 1ns / 1ps

package sme_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] TY_PUSH_POS = 2'd0;
    localparam logic [1:0] TY_PRIM     = 2'd1;
    localparam logic [1:0] TY_PUSH_NEG = 2'd2;
    localparam logic [1:0] TY_UNDEF    = 2'd3;

    localparam logic [29:0] PRIM_HALT  = 30'd0;
    localparam logic [29:0] PRIM_ADD   = 30'd1;
    localparam logic [29:0] PRIM_PRINT = 30'd5;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_HALT         = 3'd1,
        ST_UNDERFLOW    = 3'd2,
        ST_OVERFLOW     = 3'd3,
        ST_UNDEF_TYPE   = 3'd4,
        ST_UNKNOWN_PRIM = 3'd5,
        ST_STOPPED      = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        OP_RESTART,
        OP_PUSH,
        OP_UNDEF,
        OP_HALT,
        OP_ADD,
        OP_PRINT,
        OP_UNKNOWN
    } op_t;

    typedef struct packed {
        logic        action;
        logic [31:0] instruction;
    } cmd_beat_t;

    typedef struct packed {
        status_t            status;
        logic               print_valid;
        logic               print_empty;
        logic signed [31:0] print_value;
        logic               top_valid;
        logic signed [31:0] top_value;
    } rsp_beat_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
    } op_beat_t;

endpackage

### rtl/core/sme_front.sv
// Front end: accepts command beats and decodes them into operations
`timescale 1ns / 1ps

module sme_front
    import sme_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd,
    output logic      op_valid,
    input  logic      op_ready,
    output op_beat_t  op
);

    logic      valid_reg;
    logic      valid_next;
    op_beat_t  op_reg;
    op_beat_t  op_next;
    logic      take;
    logic [1:0]  ty;
    logic [29:0] data;

    assign cmd_stall = valid_reg && !op_ready;
    assign take      = cmd_valid && !cmd_stall;
    assign ty        = cmd.instruction[31:30];
    assign data      = cmd.instruction[29:0];

    always_comb
    begin
        op_next.value = {2'b00, data};
        if (cmd.action) begin
            op_next.op = OP_RESTART;
        end else begin
            case (ty)
                TY_PUSH_POS: op_next.op = OP_PUSH;
                TY_PUSH_NEG:
                begin
                    op_next.op    = OP_PUSH;
                    op_next.value = 32'd0 - {2'b00, data};
                end
                TY_PRIM:
                begin
                    if (data == PRIM_HALT) begin
                        op_next.op = OP_HALT;
                    end else if (data == PRIM_ADD) begin
                        op_next.op = OP_ADD;
                    end else if (data == PRIM_PRINT) begin
                        op_next.op = OP_PRINT;
                    end else begin
                        op_next.op = OP_UNKNOWN;
                    end
                end
                default: op_next.op = OP_UNDEF;
            endcase
        end
    end

    assign valid_next = take || (valid_reg && !op_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            op_reg <= op_next;
        end
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;

endmodule

### rtl/core/sme_queue.sv
// Short operation queue between front end and execution back end
`timescale 1ns / 1ps

module sme_queue
    import sme_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  op_beat_t push_op,
    output logic     ready,
    output logic     valid,
    input  logic     pop,
    output op_beat_t head
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    op_beat_t        entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [NW-1:0]   fill_reg;
    logic [NW-1:0]   fill_next;
    logic            do_push;
    logic            do_pop;

    assign ready   = fill_reg != NW'(QUEUE_DEPTH);
    assign valid   = fill_reg != '0;
    assign do_push = push && ready;
    assign do_pop  = pop && valid;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

### rtl/core/sme_back.sv
// Back end: executes operations on the operand stack and registers the response
`timescale 1ns / 1ps

module sme_back
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_pop,
    input  op_beat_t  op,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    `include "assert_macros.svh"

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [31:0]   mem [STACK_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    status_t       mstat_reg;
    status_t       mstat_next;
    logic [31:0]   top_reg;
    logic [31:0]   top_next;
    logic [31:0]   second_reg;
    logic [31:0]   second_next;
    logic [31:0]   third_reg;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    rsp_beat_t     rsp_reg;
    rsp_beat_t     rsp_next;
    logic          fire;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    status_t       st;
    logic          pvalid;
    logic          pempty;

    assign fire    = op_valid && (!rsp_valid_reg || !rsp_stall);
    assign op_pop  = fire;
    assign wr_addr = AW'(count_reg - CW'(2));
    assign rd_addr = AW'(count_next - CW'(3));

    always_comb
    begin
        count_next  = count_reg;
        mstat_next  = mstat_reg;
        top_next    = top_reg;
        second_next = second_reg;
        wr_en       = 1'b0;
        st          = ST_OK;
        pvalid      = 1'b0;
        pempty      = 1'b0;
        if (fire) begin
            if (op.op == OP_RESTART) begin
                count_next = '0;
                mstat_next = ST_OK;
            end else if (mstat_reg != ST_OK) begin
                st = ST_STOPPED;
            end else begin
                case (op.op)
                    OP_PUSH:
                    begin
                        if (count_reg == CW'(STACK_DEPTH)) begin
                            st = ST_OVERFLOW;
                        end else begin
                            top_next    = op.value;
                            second_next = top_reg;
                            wr_en       = count_reg >= CW'(2);
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    OP_ADD:
                    begin
                        if (count_reg < CW'(2)) begin
                            st = ST_UNDERFLOW;
                        end else begin
                            top_next    = top_reg + second_reg;
                            second_next = third_reg;
                            count_next  = count_reg - 1'b1;
                        end
                    end
                    OP_PRINT:
                    begin
                        if (count_reg == '0) begin
                            pempty = 1'b1;
                        end else begin
                            pvalid = 1'b1;
                        end
                    end
                    OP_HALT:    st = ST_HALT;
                    OP_UNDEF:   st = ST_UNDEF_TYPE;
                    default:    st = ST_UNKNOWN_PRIM;
                endcase
                mstat_next = st;
            end
        end
    end

    always_comb
    begin
        rsp_next.status      = st;
        rsp_next.print_valid = pvalid;
        rsp_next.print_empty = pempty;
        rsp_next.print_value = pvalid ? $signed(top_reg) : '0;
        rsp_next.top_valid   = count_next != '0;
        rsp_next.top_value   = (count_next != '0) ? $signed(top_next) : '0;
    end

    assign rsp_valid_next = fire || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg     <= '0;
            mstat_reg     <= ST_OK;
            rsp_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            mstat_reg     <= mstat_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg    <= top_next;
        second_reg <= second_next;
        if (fire) begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= second_reg;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            third_reg <= second_reg;
        end else begin
            third_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SME_ASSERT(a_count_bound, count_reg <= CW'(STACK_DEPTH), "stack count beyond depth")
    `SME_ASSERT_NEXT(a_stopped_status,
        fire && op.op != OP_RESTART && mstat_reg != ST_OK,
        rsp.status == ST_STOPPED, "stopped machine did not answer stopped")
    `SME_ASSERT_NEXT(a_stopped_hold,
        fire && op.op != OP_RESTART && mstat_reg != ST_OK,
        $stable(count_reg) && $stable(mstat_reg), "stopped machine changed state")
    `SME_ASSERT_NEXT(a_restart_clear, fire && op.op == OP_RESTART,
        count_reg == '0 && mstat_reg == ST_OK && !rsp.top_valid, "restart did not clear")

endmodule

### rtl/core/stack_machine_executor.sv
// Stack machine executor top level
`timescale 1ns / 1ps

// Executes one 32-bit stack-machine instruction per command beat.
// Command channel: cmd_valid / cmd_stall / cmd (action, instruction).
// action 1 restarts: the stack empties and the machine runs again.
// Response channel: rsp_valid / rsp_stall / rsp, one beat per command beat,
// in order: status, print result and the top of stack after the step.
// The response beat passes through the decode register, the queue and the
// response register after the command beat is taken.
// Throughput: one command per cycle while rsp_stall is low; the top two stack
// entries sit in registers and a one-write one-read memory holds the rest, so
// push, add and print each finish within the execute stage.
// A two-entry queue separates decode from execution.
// Reset empties the stack, clears any sticky error and drops all beats in
// flight; no clearing pass follows, commands are taken at once.
// While rsp_stall is high the response holds; the queue and decode register
// fill, then cmd_stall rises until the response beat is taken.
// After halt or an error every command answers stopped until a restart.

module stack_machine_executor
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_beat_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_beat_t rsp
);

    logic     fe_valid;
    logic     q_ready;
    op_beat_t fe_op;
    logic     q_valid;
    logic     q_pop;
    op_beat_t q_head;

    sme_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .op_valid  (fe_valid),
        .op_ready  (q_ready),
        .op        (fe_op)
    );

    sme_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fe_valid),
        .push_op (fe_op),
        .ready   (q_ready),
        .valid   (q_valid),
        .pop     (q_pop),
        .head    (q_head)
    );

    sme_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (q_valid),
        .op_pop    (q_pop),
        .op        (q_head),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
